FILE: hdl/crlf_line_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// CRLF line receiver assertion macros
// Shared property forms for the port-level checker of the line receiver.
// ----------------------------------------------------------------------------
`ifndef CRLF_LINE_RECEIVER_CORE_MACROS_SVH
`define CRLF_LINE_RECEIVER_CORE_MACROS_SVH

// Next-cycle implication, switched off while reset is high.
`define CRLFRX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define CRLFRX_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/crlfrx_pkg.sv
// ----------------------------------------------------------------------------
// CRLF line receiver package
// Types, field widths and character constants shared by the receiver modules.
// ----------------------------------------------------------------------------
package crlfrx_pkg;

   localparam int LINE_LEN_DEF = 256;
   localparam int SAVE_LEN_DEF = 80;

   localparam int CMD_W       = 3;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_L      = 8'h4C;

   typedef enum logic [CMD_W-1:0] {
      CMD_RECV        = 3'd0,
      CMD_RESTART     = 3'd1,
      CMD_READ_LINE   = 3'd2,
      CMD_READ_SAVED  = 3'd3,
      CMD_CLEAR_SAVED = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic copy_run;
      logic clear_run;
      logic load_out;
   } ctrl_type;

   typedef struct packed {
      logic clear_last;
      logic copy_go;
      logic copy_last;
      logic slot_free;
   } stat_type;

endpackage

FILE: hdl/crlf_line_receiver_core.sv
// An accepted word is executed in the EXEC state; its result is loaded into the
// result register in the OUT state once the slot is free, where the next word
// can be accepted. A CR LF ending a line that begins with '$' and has 'L' at
// position 4 adds a COPY pass that moves the line into the saved store through
// the line store read port. After reset a clearing pass zeroes both stores; no
// word is accepted until it ends. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
// CRLF line receiver core
// Collects bytes into a line until CR LF and keeps a copy of matching lines.
// ----------------------------------------------------------------------------
module crlf_line_receiver_core #(
   parameter int LINE_LEN = crlfrx_pkg::LINE_LEN_DEF,
   parameter int SAVE_LEN = crlfrx_pkg::SAVE_LEN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rx_byte [7:0], read_index [15:8].
   input  logic [crlfrx_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command [2:0].
   input  logic [crlfrx_pkg::CMD_W-1:0]       req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // line_done [0], cr_pending [1], byte_count [9:2], read_byte [17:10],
   // saved_ready [18], zero [23:19].
   output logic [crlfrx_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import crlfrx_pkg::*;

   ctrl_type ctl;
   stat_type stat;

   crlfrx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   crlfrx_dpath #(
      .LINE_LEN (LINE_LEN),
      .SAVE_LEN (SAVE_LEN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hdl/crlfrx_ctrl.sv
// ----------------------------------------------------------------------------
// CRLF line receiver controller
// Sequences the clearing pass, word execution, saved-line copy and result load.
// ----------------------------------------------------------------------------
module crlfrx_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  crlfrx_pkg::stat_type stat,
   output crlfrx_pkg::ctrl_type ctl
);
   import crlfrx_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.copy_go ? ST_COPY : ST_OUT;
         end
         ST_COPY: begin
            if (stat.copy_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.slot_free) state_in = req_tvalid ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      ctl           = '0;
      unique case (state_ff)
         ST_CLEAR: ctl.clear_run = 1'b1;
         ST_IDLE:  req_tready = 1'b1;
         ST_EXEC:  ctl.exec = 1'b1;
         ST_COPY:  ctl.copy_run = 1'b1;
         ST_OUT: begin
            req_tready   = stat.slot_free;
            ctl.load_out = stat.slot_free;
         end
         default: ;
      endcase
      ctl.accept = req_tvalid && req_tready;
   end

endmodule

FILE: hdl/crlfrx_dpath.sv
// ----------------------------------------------------------------------------
// CRLF line receiver datapath
// Line and saved stores, line flags, copy and clear counters, result register.
// ----------------------------------------------------------------------------
module crlfrx_dpath #(
   parameter int LINE_LEN = crlfrx_pkg::LINE_LEN_DEF,
   parameter int SAVE_LEN = crlfrx_pkg::SAVE_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  crlfrx_pkg::ctrl_type                 ctl,
   output crlfrx_pkg::stat_type                 stat,
   input  logic [crlfrx_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [crlfrx_pkg::CMD_W-1:0]         req_tuser,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [crlfrx_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import crlfrx_pkg::*;

   localparam int AW     = $clog2(LINE_LEN);
   localparam int SW     = $clog2(SAVE_LEN);
   localparam int CPW    = $clog2(SAVE_LEN + 1);
   localparam int MAXLEN = (LINE_LEN > SAVE_LEN) ? LINE_LEN : SAVE_LEN;
   localparam int CLW    = $clog2(MAXLEN);

   logic [7:0] line_mem  [LINE_LEN];
   logic [7:0] saved_mem [SAVE_LEN];

   cmd_type    cmd_ff;
   logic [7:0] byte_ff;
   logic [7:0] idx_ff;

   logic [AW-1:0] count_ff, count_in;
   logic          cr_ff, cr_in;
   logic          done_ff, done_in;
   logic          saved_ff, saved_in;
   logic [7:0]    head0_ff, head0_in;
   logic [7:0]    head4_ff, head4_in;

   logic [CLW-1:0] clr_ff;
   logic [CPW-1:0] cp_ff;
   logic           wr_valid_ff;
   logic [SW-1:0]  wr_idx_ff;
   logic           wr_inline_ff;

   logic [7:0] line_rd_ff;
   logic [7:0] saved_rd_ff;

   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic store_en, finish, cr_set, do_restart, do_clr_saved, match;
   logic line_we, saved_we;
   logic [AW-1:0] line_waddr, line_raddr;
   logic [7:0]    line_wdata, saved_wdata, rd_byte;
   logic [SW-1:0] saved_waddr;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff  <= cmd_type'(req_tuser);
         byte_ff <= req_tdata[7:0];
         idx_ff  <= req_tdata[15:8];
      end
   end

   always_comb begin
      store_en     = 1'b0;
      finish       = 1'b0;
      cr_set       = 1'b0;
      do_restart   = 1'b0;
      do_clr_saved = 1'b0;
      unique case (cmd_ff)
         CMD_RECV: begin
            if (!done_ff) begin
               if (cr_ff && byte_ff == CH_LF) finish = 1'b1;
               else if (!cr_ff && byte_ff == CH_CR) cr_set = 1'b1;
               else store_en = 1'b1;
            end
         end
         CMD_RESTART:     do_restart = 1'b1;
         CMD_CLEAR_SAVED: do_clr_saved = 1'b1;
         default: ;
      endcase
   end

   assign match = (head0_ff == CH_DOLLAR) && (head4_ff == CH_L);

   always_comb begin
      count_in = count_ff;
      cr_in    = cr_ff;
      done_in  = done_ff;
      saved_in = saved_ff;
      head0_in = head0_ff;
      head4_in = head4_ff;
      if (ctl.exec) begin
         if (store_en) begin
            if (count_ff == '0) head0_in = byte_ff;
            if (count_ff == AW'(4)) head4_in = byte_ff;
            if (count_ff == AW'(LINE_LEN - 1)) begin
               count_in = '0;
               cr_in    = 1'b0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         if (cr_set) cr_in = 1'b1;
         if (finish) begin
            done_in = 1'b1;
            if (match) saved_in = 1'b1;
         end
         if (do_restart) begin
            count_in = '0;
            cr_in    = 1'b0;
            done_in  = 1'b0;
         end
         if (do_clr_saved) saved_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cr_ff        <= 1'b0;
         done_ff      <= 1'b0;
         saved_ff     <= 1'b0;
         head0_ff     <= '0;
         head4_ff     <= '0;
         clr_ff       <= '0;
         cp_ff        <= '0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         cr_ff    <= cr_in;
         done_ff  <= done_in;
         saved_ff <= saved_in;
         head0_ff <= head0_in;
         head4_ff <= head4_in;
         if (ctl.clear_run) clr_ff <= clr_ff + 1'b1;
         if (ctl.exec) cp_ff <= '0;
         else if (ctl.copy_run) cp_ff <= cp_ff + 1'b1;
         wr_valid_ff <= ctl.copy_run && (int'(cp_ff) < SAVE_LEN);
         if (ctl.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff    <= SW'(cp_ff);
      wr_inline_ff <= int'(cp_ff) < LINE_LEN;
   end

   assign line_we    = (ctl.clear_run && (int'(clr_ff) < LINE_LEN)) || (ctl.exec && store_en);
   assign line_waddr = ctl.clear_run ? AW'(clr_ff) : count_ff;
   assign line_wdata = ctl.clear_run ? 8'h00 : byte_ff;
   assign line_raddr = ctl.copy_run ? AW'(cp_ff) : AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (line_we) line_mem[line_waddr] <= line_wdata;
      line_rd_ff <= line_mem[line_raddr];
   end

   assign saved_we    = (ctl.clear_run && (int'(clr_ff) < SAVE_LEN)) || wr_valid_ff;
   assign saved_waddr = ctl.clear_run ? SW'(clr_ff) : wr_idx_ff;
   assign saved_wdata = (!ctl.clear_run && wr_inline_ff) ? line_rd_ff : 8'h00;

   always_ff @(posedge clock) begin
      if (saved_we) saved_mem[saved_waddr] <= saved_wdata;
      saved_rd_ff <= saved_mem[SW'(idx_ff)];
   end

   always_comb begin
      case (cmd_ff)
         CMD_READ_LINE:  rd_byte = (int'(idx_ff) < LINE_LEN) ? line_rd_ff : 8'h00;
         CMD_READ_SAVED: rd_byte = (int'(idx_ff) < SAVE_LEN) ? saved_rd_ff : 8'h00;
         default:        rd_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_data_ff <= {5'b0, saved_ff, rd_byte, 8'(count_ff), cr_ff, done_ff};
      end
   end

   assign stat.clear_last = (clr_ff == CLW'(MAXLEN - 1));
   assign stat.copy_go    = finish && match;
   assign stat.copy_last  = (int'(cp_ff) == SAVE_LEN);
   assign stat.slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/crlfrx_checker.sv
// ----------------------------------------------------------------------------
// CRLF line receiver port checker
// Watches the receiver's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "crlf_line_receiver_core_macros.svh"

module crlfrx_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [crlfrx_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import crlfrx_pkg::*;

   `CRLFRX_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "Stalled result word changed or dropped.")
   `CRLFRX_ASSERT_NEXT_ALWAYS(a_reset_idle, reset, !rsp_tvalid && !req_tready,
      "Block not idle after reset.")
   `CRLFRX_ASSERT_NEXT(a_no_back_to_back, req_tvalid && req_tready, !req_tready,
      "Words accepted on consecutive cycles.")
   `CRLFRX_ASSERT_NEXT(a_result_follows, rsp_tvalid && rsp_tready && !req_tready,
      !rsp_tvalid, "Result shown before its word executed.")

endmodule

bind crlf_line_receiver_core crlfrx_checker u_crlfrx_checker (.*);
